// ===== rtl/lzwpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwpt_pkg
// Shared types and constants for the LZW position-table decoder.
// ----------------------------------------------------------------------------
package lzwpt_pkg;

  typedef enum logic [1:0] {
    KindLiteral = 2'd0,
    KindCopy    = 2'd1,
    KindEnd     = 2'd2
  } kind_e;

  localparam logic [8:0]  CodeClear     = 9'h100;
  localparam logic [8:0]  CodeEnd       = 9'h101;
  localparam logic [8:0]  CodeFirst     = 9'h102;
  localparam logic [8:0]  WidthSlack    = 9'h103;
  localparam logic [3:0]  CodeWidthInit = 4'd9;
  localparam logic [3:0]  ByteBits      = 4'd8;
  localparam logic [15:0] LimitReset    = 16'hFFFF;

endpackage

// ===== rtl/lzwpt_ram.sv =====
// ----------------------------------------------------------------------------
// lzwpt_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzwpt_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/lzw_position_table_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lzw_position_table_decoder_unit
// Variable-width (9 to MAX_CODE_BITS) LZW decoder emitting literal, copy and
// end tokens from a dictionary of (start position, length) entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one compressed byte per
//   transaction, msb first. Output channel out_valid_o / out_stall_i carries
//   one token per transaction. output_limit is written through cfg_we_i /
//   cfg_wdata_i while the block is idle.
//   A byte that does not complete a code is absorbed by the unpacker. A byte
//   that completes a code reads the dictionary RAM in its accept cycle and
//   writes the new entry back from the write-back stage; the input stalls
//   while that stage is full, and its token passes from the write-back stage
//   into the output register once the output is free.
//   A finished token sits in the output register; while the receiver stalls
//   it holds, and a further completed code waits in the write-back stage,
//   which then stalls the input.
//   Reset clears the bit unpacker, dictionary count and positions; the RAM
//   itself is not cleared. After an end or last token all further bytes are
//   accepted and dropped until the next reset.
// ----------------------------------------------------------------------------
module lzw_position_table_decoder_unit #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int MAX_CODE_BITS = 12,
  parameter int POS_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzwpt_pkg::kind_e   kind_o,
  output logic [7:0]         literal_byte_o,
  output logic [15:0]        src_pos_o,
  output logic [15:0]        copy_len_o,
  output logic [15:0]        dst_pos_o,
  output logic               last_o
);

  import lzwpt_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int ECW = AW + 1;
  localparam int CW  = MAX_CODE_BITS;
  localparam int OW  = POS_BITS + 1;

  // state
  logic [15:0]         limit_q;
  logic [CW-1:0]       accum_q, accum_d;
  logic [3:0]          have_q, have_d;
  logic [3:0]          width_q, width_d;
  logic [CW-1:0]       prev_q, prev_d;
  logic [ECW-1:0]      count_q, count_d;
  logic [POS_BITS-1:0] nstart_q, nstart_d;
  logic [OW-1:0]       opos_q, opos_d;
  logic                done_q, done_d;

  // write-back stage
  logic                s1_valid_q, s1_valid_d;
  logic [CW-1:0]       s1_code_q, s1_eff_q;
  logic                s1_inrange_q;

  // output register
  logic                out_valid_q, out_valid_d;
  kind_e               kind_q;
  logic [7:0]          lit_q;
  logic [15:0]         src_q, len_q, dst_q;
  logic                last_q;

  // ---------------------------------------------------------------- unpack
  logic              in_acc, take;
  logic [3:0]        need;
  logic [CW+7:0]     cat;
  logic              complete;
  logic [CW-1:0]     code_new, eff, p;
  logic              hit, inrange;
  logic [7:0]        rem;

  assign in_stall_o = s1_valid_q;
  assign in_acc     = in_valid_i && !s1_valid_q;
  assign take       = in_acc && !done_q;

  assign need     = width_q - have_q;
  assign cat      = {accum_q, in_byte_i};
  assign complete = (need <= ByteBits);
  assign code_new = CW'(cat >> (ByteBits - need));
  assign rem      = in_byte_i & (8'hFF >> need);

  assign hit = (code_new >= CW'(CodeFirst)) &&
               (32'(code_new - CW'(CodeFirst)) < 32'(count_q));
  assign eff     = hit ? code_new : prev_q;
  assign p       = eff - CW'(CodeFirst);
  assign inrange = 32'(p) < 32'(TABLE_DEPTH);

  always_comb begin
    accum_d = accum_q;
    have_d  = have_q;
    if (take) begin
      if (complete) begin
        accum_d = CW'(rem);
        have_d  = ByteBits - need;
      end else begin
        accum_d = CW'(cat);
        have_d  = have_q + ByteBits;
      end
    end
  end

  // ------------------------------------------------------------ dictionary
  logic                  fire, room, wr_en;
  logic [POS_BITS-1:0]   lnt;
  logic [2*POS_BITS-1:0] rd_data;
  logic [POS_BITS-1:0]   rd_start, rd_len;

  lzwpt_ram #(
    .Width (2 * POS_BITS),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(count_q)),
    .wr_data_i ({nstart_q, (lnt == '1) ? lnt : lnt + POS_BITS'(1)}),
    .rd_en_i   (take && complete),
    .rd_addr_i (AW'(p)),
    .rd_data_o (rd_data)
  );

  assign rd_start = rd_data[2*POS_BITS-1:POS_BITS];
  assign rd_len   = rd_data[POS_BITS-1:0];

  // ------------------------------------------------------------ write-back
  logic [OW:0]         opos_sum;
  logic [POS_BITS:0]   nstart_sum;
  logic [OW-1:0]       opos_new;
  logic [ECW-1:0]      count_new;
  logic                res;
  kind_e               kind_n;
  logic [7:0]          lit_n;
  logic [POS_BITS-1:0] src_n;

  assign fire  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign room  = 32'(count_q) < 32'(TABLE_DEPTH);

  assign opos_sum   = (OW+1)'(opos_q) + (OW+1)'(lnt);
  assign opos_new   = opos_sum[OW] ? '1 : opos_sum[OW-1:0];
  assign nstart_sum = (POS_BITS+1)'(nstart_q) + (POS_BITS+1)'(lnt);
  assign count_new  = room ? count_q + ECW'(1) : count_q;

  always_comb begin
    opos_d   = opos_q;
    nstart_d = nstart_q;
    count_d  = count_q;
    width_d  = width_q;
    prev_d   = prev_q;
    done_d   = done_q;
    res      = 1'b0;
    wr_en    = 1'b0;
    kind_n   = KindLiteral;
    lit_n    = 8'd0;
    src_n    = '0;
    lnt      = POS_BITS'(1);
    if (fire) begin
      priority if (32'(opos_q) > 32'(limit_q)) begin
        done_d = 1'b1;
        res    = 1'b1;
        kind_n = KindEnd;
        lnt    = '0;
      end else if (s1_code_q == CW'(CodeClear)) begin
        nstart_d = POS_BITS'(opos_q);
        count_d  = '0;
        width_d  = CodeWidthInit;
        prev_d   = CW'(CodeFirst);
      end else if (s1_code_q == CW'(CodeEnd)) begin
        done_d = 1'b1;
        res    = 1'b1;
        kind_n = KindEnd;
        lnt    = '0;
      end else begin
        if (s1_code_q < CW'(CodeClear)) begin
          lit_n = s1_code_q[7:0];
        end else begin
          prev_d = s1_code_q;
          if (s1_eff_q < CW'(CodeClear)) begin
            lit_n = s1_eff_q[7:0];
          end else begin
            kind_n = KindCopy;
            lnt    = s1_inrange_q ? rd_len : '0;
            src_n  = s1_inrange_q ? rd_start : '0;
          end
        end
        res      = 1'b1;
        opos_d   = opos_new;
        wr_en    = room;
        count_d  = count_new;
        nstart_d = nstart_sum[POS_BITS] ? '1 : nstart_sum[POS_BITS-1:0];
        if (32'(count_new) + 32'(WidthSlack) > (32'd1 << width_q)) begin
          width_d = (width_q == 4'(MAX_CODE_BITS)) ? width_q : width_q + 4'd1;
        end
        done_d = 32'(opos_new) > 32'(limit_q);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (fire) begin
      s1_valid_d = 1'b0;
    end else if (take && complete) begin
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && res) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      accum_q     <= '0;
      have_q      <= '0;
      width_q     <= CodeWidthInit;
      prev_q      <= '0;
      count_q     <= '0;
      nstart_q    <= '0;
      opos_q      <= '0;
      done_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      accum_q     <= accum_d;
      have_q      <= have_d;
      width_q     <= width_d;
      prev_q      <= prev_d;
      count_q     <= count_d;
      nstart_q    <= nstart_d;
      opos_q      <= opos_d;
      done_q      <= done_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && complete) begin
      s1_code_q    <= code_new;
      s1_eff_q     <= eff;
      s1_inrange_q <= inrange;
    end
    if (fire && res) begin
      kind_q <= kind_n;
      lit_q  <= lit_n;
      src_q  <= 16'(src_n);
      len_q  <= (kind_n == KindCopy) ? 16'(lnt) : 16'd0;
      dst_q  <= 16'(opos_q);
      last_q <= done_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign literal_byte_o = lit_q;
  assign src_pos_o      = src_q;
  assign copy_len_o     = len_q;
  assign dst_pos_o      = dst_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/lzwpt_checker.sv =====
// ----------------------------------------------------------------------------
// lzwpt_checker
// Port-level checks for the LZW position-table decoder, bound to the top.
// ----------------------------------------------------------------------------
module lzwpt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input lzwpt_pkg::kind_e kind_o,
  input logic [7:0]       literal_byte_o,
  input logic [15:0]      src_pos_o,
  input logic [15:0]      copy_len_o,
  input logic [15:0]      dst_pos_o,
  input logic             last_o
);

  import lzwpt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(literal_byte_o) && $stable(src_pos_o) && $stable(copy_len_o) &&
      $stable(dst_pos_o) && $stable(last_o))
    else $error("stalled token changed");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindEnd |-> last_o &&
      src_pos_o == 16'd0 && copy_len_o == 16'd0 && literal_byte_o == 8'd0)
    else $error("end token malformed");

  a_literal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindLiteral |-> src_pos_o == 16'd0 &&
      copy_len_o == 16'd0)
    else $error("literal token carries copy fields");

  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !out_stall_i |=> !out_valid_o)
    else $error("token after last");

  a_stall_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_valid_o |=> !in_stall_o)
    else $error("input stalled with free output");

endmodule

bind lzw_position_table_decoder_unit lzwpt_checker u_lzwpt_checker (.*);

// ===== tb/tb_lzw_position_table_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lzw_position_table_decoder_unit
// Self-checking bench for the LZW position-table decoder. Streams of 9 to 12
// bit codes are packed msb first into bytes and pushed through the input
// channel, while a bit-level decoder model in the bench predicts every token.
// Covers literals, copies, undefined codes, clears, dictionary growth to
// 11-bit codes, output back-pressure, the output limit register and one of
// the three ways a stream ends, picked at random per run.
// ----------------------------------------------------------------------------
module tb_lzw_position_table_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwpt_pkg::*;

  localparam int TableDepth  = 4096;
  localparam int MaxCodeBits = 12;
  localparam int PosMax      = 65535;
  localparam int OutPosMax   = 131071;
  localparam int PosBudget   = 60000;

  typedef struct {
    kind_e       kind;
    logic [7:0]  lit;
    logic [15:0] src;
    logic [15:0] len;
    logic [15:0] dst;
    logic        last;
  } token_t;

  typedef enum int {
    EndByCode,
    EndByLowLimit,
    EndByCrossing
  } stream_end_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  kind_e       kind_o;
  logic [7:0]  literal_byte_o;
  logic [15:0] src_pos_o;
  logic [15:0] copy_len_o;
  logic [15:0] dst_pos_o;
  logic        last_o;

  // decoder model state
  int limit_q;
  int code_width;
  int prev_code;
  int entry_count;
  int next_start;
  int out_pos;
  bit stream_done;
  int accum;
  int accum_bits;
  int entry_start[TableDepth];
  int entry_len[TableDepth];
  bit entry_written[TableDepth];

  token_t expected_tokens[$];
  bit     pending_bits[$];

  int fail_count;
  int bytes_sent;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_cycles;

  lzw_position_table_decoder_unit uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic void reset_decoder();
    limit_q     = LimitReset;
    code_width  = CodeWidthInit;
    prev_code   = 0;
    entry_count = 0;
    next_start  = 0;
    out_pos     = 0;
    stream_done = 1'b0;
    accum       = 0;
    accum_bits  = 0;
    for (int i = 0; i < TableDepth; i++) begin
      entry_start[i]   = 0;
      entry_len[i]     = 0;
      entry_written[i] = 1'b0;
    end
  endfunction

  // dictionary index a code would read, -1 when it reads none
  function automatic int entry_read_by(int code);
    int named;
    if (code < int'(CodeFirst)) return -1;
    named = (code - int'(CodeFirst) < entry_count) ? code : prev_code;
    return (named < int'(CodeClear)) ? -1 : named - int'(CodeFirst);
  endfunction

  function automatic void decode_code(int code);
    token_t t;
    int     span;
    int     idx;
    t.kind = KindLiteral;
    t.lit  = '0;
    t.src  = '0;
    t.len  = '0;
    t.dst  = 16'(out_pos);
    t.last = 1'b0;
    span   = 1;
    if (out_pos > limit_q || code == int'(CodeEnd)) begin
      stream_done = 1'b1;
      t.kind = KindEnd;
      t.last = 1'b1;
      expected_tokens.push_back(t);
      return;
    end
    if (code == int'(CodeClear)) begin
      next_start  = out_pos;
      entry_count = 0;
      code_width  = CodeWidthInit;
      prev_code   = CodeFirst;
      return;
    end
    if (code < int'(CodeClear)) begin
      t.lit = 8'(code);
    end else begin
      idx = entry_read_by(code);
      if (idx < 0) begin
        t.lit = 8'(prev_code);
      end else begin
        t.kind = KindCopy;
        t.src  = 16'(entry_start[idx]);
        span   = entry_len[idx];
        t.len  = 16'(span);
      end
      prev_code = code;
    end
    out_pos = (out_pos + span > OutPosMax) ? OutPosMax : out_pos + span;
    if (entry_count < TableDepth) begin
      entry_start[entry_count]   = next_start;
      entry_len[entry_count]     = (span + 1 > PosMax) ? PosMax : span + 1;
      entry_written[entry_count] = 1'b1;
      entry_count++;
    end
    next_start = (next_start + span > PosMax) ? PosMax : next_start + span;
    if (entry_count + int'(WidthSlack) > (1 << code_width))
      code_width = (code_width < MaxCodeBits) ? code_width + 1 : MaxCodeBits;
    if (out_pos > limit_q) stream_done = 1'b1;
    t.last = stream_done;
    expected_tokens.push_back(t);
  endfunction

  function automatic void take_bit(bit b);
    int code;
    if (stream_done) return;
    accum = ((accum << 1) | b) & 'hFFF;
    accum_bits++;
    if (accum_bits >= code_width) begin
      code       = accum;
      accum      = 0;
      accum_bits = 0;
      decode_code(code);
    end
  endfunction

  // random code that never reads an unwritten entry and keeps out_pos in budget
  function automatic int pick_code(int max_len, int clear_pct);
    int roll;
    int top;
    int code;
    int idx;
    int n;
    roll = $urandom_range(0, 99);
    top  = (1 << code_width) - 1;
    code = $urandom_range(0, 255);
    if (roll < clear_pct) return CodeClear;
    if (roll >= 45) begin
      if (roll < 60 && int'(CodeFirst) + entry_count <= top) begin
        code = (roll < 52) ? int'(CodeFirst) + entry_count
                           : $urandom_range(int'(CodeFirst) + entry_count, top);
      end else if (entry_count > 0) begin
        n = top - int'(CodeFirst) + 1;
        if (entry_count < n) n = entry_count;
        code = int'(CodeFirst) + $urandom_range(0, n - 1);
      end
    end
    idx = entry_read_by(code);
    if (idx >= 0 && (!entry_written[idx] || entry_len[idx] > max_len ||
                     out_pos + entry_len[idx] > PosBudget))
      code = $urandom_range(0, 255);
    return code;
  endfunction

  // ------------------------------------------------------------- checking

  function automatic void check_field(string field, logic [15:0] want,
                                      logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        fail_count++;
        $display("%0t: token expected none actual kind %0d dst %0h",
                 $time, kind_o, dst_pos_o);
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind_o));
        check_field("literal_byte", 16'(want.lit), 16'(literal_byte_o));
        check_field("src_pos", want.src, src_pos_o);
        check_field("copy_len", want.len, copy_len_o);
        check_field("dst_pos", want.dst, dst_pos_o);
        check_field("last", 16'(want.last), 16'(last_o));
      end
    end
  end

  // output stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // ------------------------------------------------------------- drivers

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic flush_bytes();
    logic [7:0] b;
    while (pending_bits.size() >= 8) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], pending_bits.pop_front()};
      send_byte(b);
    end
  endtask

  task automatic emit_code(int code);
    int w;
    w = code_width;
    for (int i = w - 1; i >= 0; i--) begin
      pending_bits.push_back(code[i]);
      take_bit(code[i]);
    end
    flush_bytes();
  endtask

  // pad with whole codes until the stream sits on a byte boundary
  task automatic align_stream();
    int r;
    while (pending_bits.size() != 0) begin
      r = pending_bits.size();
      if (code_width % 2 == 0 &&
          (r % 2 == 1 || (code_width == MaxCodeBits && r % 4 != 0)))
        emit_code(CodeClear);
      else
        emit_code(pick_code(8, 0));
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_q = v;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    int dir_codes[$];
    // undefined code before any clear, literal extremes, defined copy,
    // code equal to the next entry, undefined code far ahead, clear, and
    // undefined code right after a clear (reads a stale entry)
    dir_codes = '{'h1FF, 'h0FF, 'h000, 'h000, 'h102, 'h107, 'h1FE, 'h108,
                  CodeClear, 'h1FF, 'h041, 'h103, 'h080};
    write_limit(LimitReset);
    foreach (dir_codes[i]) emit_code(dir_codes[i]);
    align_stream();
    quiesce();
  endtask

  task automatic test_table_growth();
    write_limit(16'(PosBudget));
    while (code_width < 11) emit_code(pick_code(4, 0));
    repeat (40) emit_code(pick_code(4, 0));
    align_stream();
    quiesce();
  endtask

  task automatic test_random_traffic();
    int goal;
    emit_code(CodeClear);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct  = 49;
        sink_idle_pct = 33;
        write_limit(16'($urandom_range(PosBudget, PosMax - 1)));
      end else if (phase == 2) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_limit(LimitReset);
      end
      goal = bytes_sent + 210;
      while (bytes_sent < goal) emit_code(pick_code(40, 1));
      align_stream();
      quiesce();
    end
  endtask

  task automatic test_backpressure();
    @(posedge clk_i);
    hold_cycles = 400;
    @(negedge clk_i);
    repeat (60) emit_code(pick_code(40, 1));
    align_stream();
    quiesce();
  endtask

  task automatic test_stream_end();
    stream_end_e how;
    how = stream_end_e'($urandom_range(0, 2));
    case (how)
      EndByCode: begin
        emit_code(CodeEnd);
      end
      EndByLowLimit: begin
        write_limit('0);
        emit_code(pick_code(40, 0));
      end
      default: begin
        write_limit(16'(out_pos));
        while (!stream_done) emit_code(pick_code(40, 0));
      end
    endcase
    // leftover bits plus trailing bytes, all dropped by the block
    repeat ((8 - pending_bits.size()) % 8 + 80)
      pending_bits.push_back($urandom_range(0, 1));
    flush_bytes();
    quiesce();
  endtask

  // ----------------------------------------------------------------- main

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_byte_i     = '0;
    out_stall_i   = 1'b0;
    fail_count    = 0;
    bytes_sent    = 0;
    hold_cycles   = 0;
    src_idle_pct  = 33;
    sink_idle_pct = 49;
    reset_decoder();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_growth();
    test_random_traffic();
    test_backpressure();
    test_stream_end();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
